FILE: rtl/neom_pkg.sv
// ============================================================================
// neom_pkg
// Shared types, sizes and codes of the note on/off event merger.
// ============================================================================
package neom_pkg;

    // Pending note-off table size and the widths that follow from it
    localparam int PENDING_DEPTH = 16;
    localparam int IDX_W = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam int CNT_W = $clog2(PENDING_DEPTH + 1);

    // Fixed field widths
    localparam int TIME_W  = 32;
    localparam int KEY_W   = 8;
    localparam int VEL_W   = 8;
    localparam int STAT_W  = 2;
    localparam int OUTC_W  = 2;
    localparam int PCNT_W  = 5;

    // Stream payload widths
    localparam int IN_DATA_W  = 120;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 64;
    localparam int OUT_USER_W = 1;

    // Link answer codes
    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd1;

    // Outcome codes
    localparam logic [OUTC_W-1:0] OUTC_SENT  = 2'd0;
    localparam logic [OUTC_W-1:0] OUTC_IDLE  = 2'd1;
    localparam logic [OUTC_W-1:0] OUTC_FULL  = 2'd2;
    localparam logic [OUTC_W-1:0] OUTC_ERROR = 2'd3;

    // One pending note-off entry as stored in the table RAM
    typedef struct packed {
        logic [TIME_W-1:0] off_time;
        logic [KEY_W-1:0]  off_key;
    } t_entry;

    // Running minimum held by the compare unit
    typedef struct packed {
        logic [TIME_W-1:0] off_time;
        logic [KEY_W-1:0]  off_key;
        logic [IDX_W-1:0]  slot;
    } t_best;

    // Map a link answer to the reported outcome
    function automatic logic [OUTC_W-1:0] link_outcome(input logic [STAT_W-1:0] status);
        logic [OUTC_W-1:0] res;
        case (status)
            ST_OK:   res = OUTC_SENT;
            ST_FULL: res = OUTC_FULL;
            default: res = OUTC_ERROR;
        endcase
        return res;
    endfunction

endpackage

FILE: rtl/neom_ram.sv
// ============================================================================
// neom_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ============================================================================
module neom_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/neom_min_unit.sv
// ============================================================================
// neom_min_unit
// Compare unit: keeps the earliest off time seen during a table scan.
// ============================================================================
module neom_min_unit (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_clear,
    input  logic                     i_valid,
    input  logic [neom_pkg::IDX_W-1:0] i_slot,
    input  neom_pkg::t_entry         i_entry,
    output neom_pkg::t_best          o_best
);

    logic            r_have;
    neom_pkg::t_best r_best;
    logic            take;

    // Strict less-than keeps the lowest slot on equal times
    assign take = i_valid && (!r_have || (i_entry.off_time < r_best.off_time));

    // Presence flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
        end else if (i_clear) begin
            r_have <= 1'b0;
        end else if (i_valid) begin
            r_have <= 1'b1;
        end
    end

    // Best entry payload
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_best.off_time <= i_entry.off_time;
            r_best.off_key  <= i_entry.off_key;
            r_best.slot     <= i_slot;
        end
    end

    assign o_best = r_best;

endmodule

FILE: rtl/note_on_off_event_merger.sv
// ============================================================================
// note_on_off_event_merger
// Merges a note-on stream with a table of pending note-offs, at most one event a step.
// ============================================================================
//
//  channel  | dir | tdata (low bit up)                              | tuser
//  ---------+-----+-------------------------------------------------+-----------
//  s_axis   | in  | has_note, note_start, note_key, note_velocity,  | mode
//           |     | note_length, window_end, sink_status            |
//  m_axis   | out | event_valid, event_key, event_velocity,         | event_is_on
//           |     | event_time, note_taken, outcome, off_dropped,   |
//           |     | pending_count                                   |
//
//  A step scans the pending entries, then decides the event; removing an off
//  adds a swap read and write, and all-off or an empty table skips the scan.
//  Step length is set by the scan of the table through the single read port
//  of the table RAM, one entry per cycle.
//  Synchronous active-low reset empties the table; no clearing pass is needed.
//  s_axis_tready is high only while idle; a result waiting on m_axis does not
//  block the next accept, the step stalls at its end until the output is free.
// ============================================================================
module note_on_off_event_merger (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [0] has_note, [32:1] note_start, [40:33] note_key, [48:41] note_velocity,
    // [80:49] note_length, [112:81] window_end, [114:113] sink_status
    input  logic [neom_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // [0] mode
    input  logic [neom_pkg::IN_USER_W-1:0]     s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [0] event_valid, [8:1] event_key, [16:9] event_velocity, [48:17] event_time,
    // [49] note_taken, [51:50] outcome, [52] off_dropped, [57:53] pending_count
    output logic [neom_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // [0] event_is_on
    output logic [neom_pkg::OUT_USER_W-1:0]    m_axis_tuser
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_MOVE_RD,
        S_MOVE_WR,
        S_OUT
    } t_state;

    typedef struct packed {
        logic                          event_valid;
        logic                          event_is_on;
        logic [neom_pkg::KEY_W-1:0]    event_key;
        logic [neom_pkg::VEL_W-1:0]    event_velocity;
        logic [neom_pkg::TIME_W-1:0]   event_time;
        logic                          note_taken;
        logic [neom_pkg::OUTC_W-1:0]   outcome;
        logic                          off_dropped;
    } t_result;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    t_state                          r_state,    n_state;
    logic [neom_pkg::CNT_W-1:0]      r_count,    n_count;
    logic [neom_pkg::CNT_W-1:0]      r_idx,      n_idx;
    logic                            r_pend,     n_pend;
    logic [neom_pkg::IDX_W-1:0]      r_pend_idx, n_pend_idx;
    t_result                         r_res,      n_res;
    logic                            r_out_valid, n_out_valid;
    logic [neom_pkg::OUT_DATA_W-1:0] r_out_data, n_out_data;
    logic [neom_pkg::OUT_USER_W-1:0] r_out_user, n_out_user;

    // Latched input transaction
    logic                            r_mode;
    logic                            r_has_note;
    logic [neom_pkg::TIME_W-1:0]     r_note_start;
    logic [neom_pkg::KEY_W-1:0]      r_note_key;
    logic [neom_pkg::VEL_W-1:0]      r_note_vel;
    logic [neom_pkg::TIME_W-1:0]     r_off_end;
    logic [neom_pkg::TIME_W-1:0]     r_window_end;
    logic [neom_pkg::STAT_W-1:0]     r_status;

    // RAM and compare unit hookup
    logic                            ram_we;
    logic [neom_pkg::IDX_W-1:0]      ram_waddr;
    neom_pkg::t_entry                ram_wdata;
    logic [neom_pkg::IDX_W-1:0]      ram_raddr;
    neom_pkg::t_entry                ram_rdata;
    logic                            min_clear;
    neom_pkg::t_best                 best;

    logic                            in_acc;
    logic                            use_off;
    logic [neom_pkg::TIME_W-1:0]     ev_time;
    logic [neom_pkg::CNT_W+neom_pkg::PCNT_W-1:0] cnt_ext;

    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);

    // Input field capture; the note-off time is formed here
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mode       <= s_axis_tuser[0];
            r_has_note   <= s_axis_tdata[0];
            r_note_start <= s_axis_tdata[32:1];
            r_note_key   <= s_axis_tdata[40:33];
            r_note_vel   <= s_axis_tdata[48:41];
            r_off_end    <= s_axis_tdata[32:1] + s_axis_tdata[80:49];
            r_window_end <= s_axis_tdata[112:81];
            r_status     <= s_axis_tdata[114:113];
        end
    end

    // Pending table storage
    neom_ram #(
        .WIDTH ($bits(neom_pkg::t_entry)),
        .DEPTH (neom_pkg::PENDING_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Earliest-off search
    neom_min_unit u_min (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (min_clear),
        .i_valid (r_pend),
        .i_slot  (r_pend_idx),
        .i_entry (ram_rdata),
        .o_best  (best)
    );

    assign min_clear = in_acc;
    assign use_off   = (r_count != '0) && (!r_has_note || (best.off_time <= r_note_start));
    assign ev_time   = use_off ? best.off_time : r_note_start;
    assign cnt_ext   = {{neom_pkg::PCNT_W{1'b0}}, r_count};

    // ------------------------------------------------------------------
    // Sequencer next-state logic
    // ------------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_pend      = 1'b0;
        n_pend_idx  = r_idx[neom_pkg::IDX_W-1:0];
        n_res       = r_res;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        n_out_user  = r_out_user;
        ram_we      = 1'b0;
        ram_waddr   = r_count[neom_pkg::IDX_W-1:0];
        ram_wdata   = '{off_time: r_off_end, off_key: r_note_key};
        ram_raddr   = r_idx[neom_pkg::IDX_W-1:0];

        case (r_state)
            S_IDLE: begin
                n_idx = '0;
                if (in_acc) begin
                    if (s_axis_tuser[0] || (r_count == '0)) begin
                        n_state = S_DECIDE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end

            // One table read issued per cycle, compared in the next cycle
            S_SCAN: begin
                if (r_idx < r_count) begin
                    n_idx  = r_idx + 1'b1;
                    n_pend = 1'b1;
                end else if (!r_pend) begin
                    n_state = S_DECIDE;
                end
            end

            S_DECIDE: begin
                n_res   = '0;
                n_state = S_OUT;
                if (r_mode) begin
                    // All-off: the table empties whatever the link says
                    n_count       = '0;
                    n_res.outcome = neom_pkg::link_outcome(r_status);
                end else if ((!use_off && !r_has_note) || (ev_time > r_window_end)) begin
                    n_res.outcome = neom_pkg::OUTC_IDLE;
                end else begin
                    n_res.event_valid    = 1'b1;
                    n_res.event_time     = ev_time;
                    n_res.event_is_on    = !use_off;
                    n_res.event_key      = use_off ? best.off_key : r_note_key;
                    n_res.event_velocity = use_off ? '0 : r_note_vel;
                    n_res.outcome        = neom_pkg::link_outcome(r_status);
                    case (r_status)
                        neom_pkg::ST_OK: begin
                            if (use_off) begin
                                // Swap-remove: last entry moves into the slot
                                n_count = r_count - 1'b1;
                                n_state = S_MOVE_RD;
                            end else begin
                                n_res.note_taken = 1'b1;
                                if (r_count < neom_pkg::CNT_W'(neom_pkg::PENDING_DEPTH)) begin
                                    ram_we  = 1'b1;
                                    n_count = r_count + 1'b1;
                                end else begin
                                    n_res.off_dropped = 1'b1;
                                end
                            end
                        end
                        neom_pkg::ST_FULL: begin
                            n_count = r_count;
                        end
                        default: begin
                            n_count = '0;
                        end
                    endcase
                end
            end

            S_MOVE_RD: begin
                ram_raddr = r_count[neom_pkg::IDX_W-1:0];
                n_state   = S_MOVE_WR;
            end

            S_MOVE_WR: begin
                ram_we    = 1'b1;
                ram_waddr = best.slot;
                ram_wdata = ram_rdata;
                n_state   = S_OUT;
            end

            // Hand the result over once the output register is free
            S_OUT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_user  = r_res.event_is_on;
                    n_out_data  = {6'd0, cnt_ext[neom_pkg::PCNT_W-1:0], r_res.off_dropped,
                                   r_res.outcome, r_res.note_taken, r_res.event_time,
                                   r_res.event_velocity, r_res.event_key, r_res.event_valid};
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // State and registered outputs
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
        r_pend_idx <= n_pend_idx;
        r_res      <= n_res;
        r_out_data <= n_out_data;
        r_out_user <= n_out_user;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= neom_pkg::CNT_W'(neom_pkg::PENDING_DEPTH))
        else $error("pending count above table depth");

    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_DECIDE || r_state == S_MOVE_WR))
        else $error("table write outside decide or move");

    a_scan_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECIDE) |-> !r_pend)
        else $error("decision taken with a compare still in flight");

    a_move_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MOVE_WR) |-> $past(r_state) == S_MOVE_RD)
        else $error("swap write without its read");

    a_result_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_data[0]) |-> (!r_out_data[49] && !r_out_data[52]))
        else $error("note taken or off dropped without an event");

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// Self-checking bench for the note on/off event merger. A queue of note steps
// (directed corner cases, then time-ordered random runs with some noise) is
// streamed in through the slave side. An in-bench model of the pending
// note-off table predicts each result, and the monitor compares every result
// against the oldest prediction. Sender gaps and receiver stalls change from
// phase to phase.
// ============================================================================
module tb_top;

    // Link answers not named in the package
    localparam logic [neom_pkg::STAT_W-1:0] ST_ERROR = 2'd2;
    localparam logic [neom_pkg::STAT_W-1:0] ST_UNDEF = 2'd3;

    // Cycles without any transaction before the run is declared hung
    localparam int STALL_LIMIT = 4000;

    // One input step as seen by the note source and the link
    typedef struct {
        logic                        mode;
        logic                        has_note;
        logic [neom_pkg::TIME_W-1:0] note_start;
        logic [neom_pkg::KEY_W-1:0]  note_key;
        logic [neom_pkg::VEL_W-1:0]  note_vel;
        logic [neom_pkg::TIME_W-1:0] note_len;
        logic [neom_pkg::TIME_W-1:0] window_end;
        logic [neom_pkg::STAT_W-1:0] sink_status;
    } t_note_step;

    // One result, compared field by field through packed equality
    typedef struct packed {
        logic                        ev_valid;
        logic                        ev_is_on;
        logic [neom_pkg::KEY_W-1:0]  ev_key;
        logic [neom_pkg::VEL_W-1:0]  ev_vel;
        logic [neom_pkg::TIME_W-1:0] ev_time;
        logic                        note_taken;
        logic [neom_pkg::OUTC_W-1:0] outcome;
        logic                        off_dropped;
        logic [neom_pkg::PCNT_W-1:0] pend_count;
    } t_event_result;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [neom_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [neom_pkg::IN_USER_W-1:0]  s_axis_tuser = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [neom_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic [neom_pkg::OUT_USER_W-1:0] m_axis_tuser;

    t_note_step    note_step_q[$];
    t_event_result event_result_q[$];
    t_note_step    drive_step;

    // Model copy of the pending note-off table
    logic [neom_pkg::TIME_W-1:0] pend_off_time [neom_pkg::PENDING_DEPTH];
    logic [neom_pkg::KEY_W-1:0]  pend_off_key  [neom_pkg::PENDING_DEPTH];
    int                          pend_cnt = 0;

    int          src_gap_pct = 0;
    int          sink_stall_pct = 0;
    int          mismatch_cnt = 0;
    int          quiet_cycles = 0;
    logic [31:0] clock_ms = '0;

    note_on_off_event_merger u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Outcome reported for a link answer
    function automatic logic [neom_pkg::OUTC_W-1:0] answer_outcome(
        input logic [neom_pkg::STAT_W-1:0] st
    );
        if (st == neom_pkg::ST_OK) begin
            return neom_pkg::OUTC_SENT;
        end else if (st == neom_pkg::ST_FULL) begin
            return neom_pkg::OUTC_FULL;
        end
        return neom_pkg::OUTC_ERROR;
    endfunction

    // Pick the earliest event, offer it if due, then apply the link answer
    function automatic t_event_result next_event_result(input t_note_step st);
        t_event_result               res;
        int                          slot;
        logic                        use_off;
        logic [neom_pkg::TIME_W-1:0] ev_time;
        res = '0;
        slot = 0;
        if (st.mode) begin
            pend_cnt = 0;
            res.outcome = answer_outcome(st.sink_status);
            return res;
        end
        // strict less-than: ties stay with the lowest slot
        for (int i = 1; i < pend_cnt; i++) begin
            if (pend_off_time[neom_pkg::IDX_W'(i)] < pend_off_time[neom_pkg::IDX_W'(slot)]) begin
                slot = i;
            end
        end
        use_off = (pend_cnt > 0) &&
                  (!st.has_note || pend_off_time[neom_pkg::IDX_W'(slot)] <= st.note_start);
        ev_time = use_off ? pend_off_time[neom_pkg::IDX_W'(slot)] : st.note_start;
        if ((!use_off && !st.has_note) || ev_time > st.window_end) begin
            res.outcome = neom_pkg::OUTC_IDLE;
            res.pend_count = pend_cnt[neom_pkg::PCNT_W-1:0];
            return res;
        end
        res.ev_valid = 1'b1;
        res.ev_time = ev_time;
        if (use_off) begin
            res.ev_key = pend_off_key[neom_pkg::IDX_W'(slot)];
        end else begin
            res.ev_is_on = 1'b1;
            res.ev_key = st.note_key;
            res.ev_vel = st.note_vel;
        end
        if (st.sink_status == neom_pkg::ST_OK) begin
            if (use_off) begin
                // swap-remove with the last entry
                pend_off_time[neom_pkg::IDX_W'(slot)] = pend_off_time[neom_pkg::IDX_W'(pend_cnt-1)];
                pend_off_key[neom_pkg::IDX_W'(slot)] = pend_off_key[neom_pkg::IDX_W'(pend_cnt-1)];
                pend_cnt--;
            end else begin
                if (pend_cnt < neom_pkg::PENDING_DEPTH) begin
                    pend_off_time[neom_pkg::IDX_W'(pend_cnt)] = st.note_start + st.note_len;
                    pend_off_key[neom_pkg::IDX_W'(pend_cnt)] = st.note_key;
                    pend_cnt++;
                end else begin
                    res.off_dropped = 1'b1;
                end
                res.note_taken = 1'b1;
            end
        end else if (st.sink_status != neom_pkg::ST_FULL) begin
            pend_cnt = 0;
        end
        res.outcome = answer_outcome(st.sink_status);
        res.pend_count = pend_cnt[neom_pkg::PCNT_W-1:0];
        return res;
    endfunction

    function automatic string fmt_result(input t_event_result r);
        return $sformatf("valid=%0d on=%0d key=%02h vel=%02h time=%08h %s",
            r.ev_valid, r.ev_is_on, r.ev_key, r.ev_vel, r.ev_time,
            $sformatf("taken=%0d outc=%0d drop=%0d cnt=%0d",
                      r.note_taken, r.outcome, r.off_dropped, r.pend_count));
    endfunction

    task automatic queue_step(
        input logic                        mode,
        input logic                        has_note,
        input logic [neom_pkg::TIME_W-1:0] start,
        input logic [neom_pkg::KEY_W-1:0]  key,
        input logic [neom_pkg::VEL_W-1:0]  vel,
        input logic [neom_pkg::TIME_W-1:0] len,
        input logic [neom_pkg::TIME_W-1:0] win,
        input logic [neom_pkg::STAT_W-1:0] st
    );
        t_note_step it;
        it.mode = mode;
        it.has_note = has_note;
        it.note_start = start;
        it.note_key = key;
        it.note_vel = vel;
        it.note_len = len;
        it.window_end = win;
        it.sink_status = st;
        note_step_q.push_back(it);
    endtask

    // Random link answer, mostly ok
    function automatic logic [neom_pkg::STAT_W-1:0] pick_answer(input int ok_pct,
                                                                input int full_pct);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < ok_pct) return neom_pkg::ST_OK;
        if (pick < ok_pct + full_pct) return neom_pkg::ST_FULL;
        if (pick < 97) return ST_ERROR;
        return ST_UNDEF;
    endfunction

    // Runs of time-ordered notes with a moving window, some noise, some all-offs
    task automatic add_random_steps(input int count);
        int   made;
        int   run_len;
        logic dense;
        logic [neom_pkg::TIME_W-1:0] len;
        made = 0;
        while (made < count) begin
            run_len = $urandom_range(5, 40);
            if (run_len > count - made) run_len = count - made;
            dense = ($urandom_range(0, 2) == 0);
            if ($urandom_range(0, 3) == 0) clock_ms = $urandom;
            repeat (run_len) begin
                if ($urandom_range(0, 99) < 4) begin
                    queue_step(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom,
                               neom_pkg::KEY_W'($urandom_range(0, 255)),
                               neom_pkg::VEL_W'($urandom_range(0, 255)), $urandom,
                               $urandom, neom_pkg::STAT_W'($urandom_range(0, 3)));
                end else begin
                    clock_ms += $urandom_range(0, dense ? 3 : 25);
                    if (dense) begin
                        len = $urandom_range(200, 5000);
                    end else if ($urandom_range(0, 9) == 0) begin
                        len = $urandom;
                    end else begin
                        len = $urandom_range(0, 60);
                    end
                    // dense runs fill the table, normal runs let offs fall due
                    queue_step(1'b0, $urandom_range(0, 9) != 0, clock_ms,
                               neom_pkg::KEY_W'($urandom_range(0, 255)),
                               neom_pkg::VEL_W'($urandom_range(0, 255)), len,
                               clock_ms + $urandom_range(0, 60) - 32'd20,
                               dense ? pick_answer(95, 5) : pick_answer(85, 7));
                end
                made++;
            end
            if ($urandom_range(0, 2) == 0) begin
                queue_step(1'b1, 1'($urandom_range(0, 1)), $urandom,
                           neom_pkg::KEY_W'($urandom_range(0, 255)),
                           neom_pkg::VEL_W'($urandom_range(0, 255)), $urandom, $urandom,
                           neom_pkg::STAT_W'($urandom_range(0, 3)));
                made++;
            end
        end
    endtask

    // Hold off until every queued step is accepted and every result is back
    task automatic wait_for_drain();
        @(negedge i_clk);
        while (note_step_q.size() != 0 || s_axis_tvalid || event_result_q.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Sender: one transaction per step, random gaps per phase
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                event_result_q.push_back(next_event_result(drive_step));
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (note_step_q.size() != 0 && $urandom_range(0, 99) >= src_gap_pct) begin
                    drive_step = note_step_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {5'd0, drive_step.sink_status, drive_step.window_end,
                                     drive_step.note_len, drive_step.note_vel,
                                     drive_step.note_key, drive_step.note_start,
                                     drive_step.has_note};
                    s_axis_tuser <= drive_step.mode;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each result transaction against the oldest prediction
    always @(posedge i_clk) begin
        t_event_result got;
        t_event_result want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.ev_valid = m_axis_tdata[0];
                got.ev_is_on = m_axis_tuser[0];
                got.ev_key = m_axis_tdata[8:1];
                got.ev_vel = m_axis_tdata[16:9];
                got.ev_time = m_axis_tdata[48:17];
                got.note_taken = m_axis_tdata[49];
                got.outcome = m_axis_tdata[51:50];
                got.off_dropped = m_axis_tdata[52];
                got.pend_count = m_axis_tdata[57:53];
                if (event_result_q.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10) $display("unexpected result: %s", fmt_result(got));
                end else begin
                    want = event_result_q.pop_front();
                    if (got != want) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10) begin
                            $display("mismatch\n  exp: %s\n  act: %s", fmt_result(want),
                                     fmt_result(got));
                        end
                    end
                end
            end
            m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // Watchdog on cycles with no transaction on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Stimulus and phases
    initial begin
        int gap_by_phase [4];
        int stall_by_phase [4];
        gap_by_phase = '{0, 88, 0, 22};
        stall_by_phase = '{0, 0, 88, 22};

        // nothing pending, no note; then a note not yet due
        queue_step(1'b0, 1'b0, 32'd0, 8'h00, 8'h00, 32'd0, 32'd0, neom_pkg::ST_OK);
        queue_step(1'b0, 1'b1, 32'd10, 8'h00, 8'h00, 32'd0, 32'd0, neom_pkg::ST_OK);
        // note sent, off at 15; next note at 15 ties and the off wins
        queue_step(1'b0, 1'b1, 32'd10, 8'h12, 8'h34, 32'd5, 32'd10, neom_pkg::ST_OK);
        queue_step(1'b0, 1'b1, 32'd15, 8'hFF, 8'hFF, 32'd0, 32'hFFFF_FFFF, neom_pkg::ST_OK);
        // off time wraps past 2^32 to 14
        queue_step(1'b0, 1'b1, 32'd15, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   neom_pkg::ST_OK);
        // link full leaves all as is; link error on an off clears the table
        queue_step(1'b0, 1'b1, 32'hFFFF_FFF0, 8'h40, 8'h7F, 32'h20, 32'hFFFF_FFFF,
                   neom_pkg::ST_FULL);
        queue_step(1'b0, 1'b0, 32'd0, 8'h00, 8'h00, 32'd0, 32'd14, ST_ERROR);
        // fill the table with equal off times; the last note's off is dropped
        for (int k = 0; k <= neom_pkg::PENDING_DEPTH; k++) begin
            queue_step(1'b0, 1'b1, neom_pkg::TIME_W'(k), neom_pkg::KEY_W'(8'h60 + k),
                       neom_pkg::VEL_W'(k), 32'd1000 - k, 32'hFFFF_FFFF, neom_pkg::ST_OK);
        end
        // two pulls on tied offs exercise lowest-slot selection after a swap
        queue_step(1'b0, 1'b0, 32'd0, 8'h00, 8'h00, 32'd0, 32'hFFFF_FFFF, neom_pkg::ST_OK);
        queue_step(1'b0, 1'b0, 32'd0, 8'h00, 8'h00, 32'd0, 32'hFFFF_FFFF, neom_pkg::ST_OK);
        // all-off with the undefined link code
        queue_step(1'b1, 1'b1, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   ST_UNDEF);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait_for_drain();

        // random phases, each started from an empty pipeline
        for (int ph = 0; ph < 5; ph++) begin
            src_gap_pct = gap_by_phase[2'(ph % 4)];
            sink_stall_pct = stall_by_phase[2'(ph % 4)];
            add_random_steps(145);
            wait_for_drain();
        end

        repeat (30) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/neom_pkg.sv
rtl/neom_ram.sv
rtl/neom_min_unit.sv
rtl/note_on_off_event_merger.sv
sim/tb_top.sv
